// ===== rtl/core/lrfp_pkg.sv =====
// Shared constants and control types for the fixed-point line rasterizer.
package lrfp_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int COLOR_W        = 32;

  localparam int FRAC_WIDE   = 16;
  localparam int FRAC_NARROW = 8;
  localparam logic [FRAC_WIDE-1:0] HALF_WIDE   = 16'h8000;
  localparam logic [FRAC_WIDE-1:0] HALF_NARROW = 16'h0080;

  // quotient magnitude reaches 2^FRAC_WIDE, so one extra bit, then a sign bit
  localparam int QUO_W = FRAC_WIDE + 1;
  localparam int INC_W = QUO_W + 1;
  localparam int CNT_W = $clog2(FRAC_WIDE + 1);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic start;
    logic advance;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/lrfp_intf.sv =====
// Valid/ready channel interfaces for line items, pixels and the config write.
interface lrfp_item_if #(
  parameter int COORD_BITS = 13
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [31:0]                  line_color;

  modport source (output valid, action, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink (input valid, action, x_start, y_start, x_end, y_end, line_color,
                output ready);
endinterface

interface lrfp_pixel_if #(
  parameter int COORD_BITS = 13
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [31:0]                  pixel_color;
  logic                         pixel_valid;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
                output ready);
endinterface

interface lrfp_cfg_if;
  logic valid;
  logic ready;
  logic narrow_fraction;

  modport source (output valid, narrow_fraction, input ready);
  modport sink (input valid, narrow_fraction, output ready);
endinterface

// ===== rtl/core/lrfp_ctrl.sv =====
// Controller: input/output handshake, output occupancy and divide sequencing.
module lrfp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lrfp_pkg::ctrl_cmd_t  cmd_o,
  input  lrfp_pkg::dp_stat_t   stat_i
);
  import lrfp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.start    = accept && (in_action_i == ACT_START);
  assign cmd_o.advance  = accept && (in_action_i == ACT_ADVANCE);
  assign cmd_o.div_step = (state_q == ST_DIV);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/lrfp_datapath.sv =====
// Datapath: line setup, serial increment divider, DDA stepper and output register.
module lrfp_datapath #(
  parameter int COORD_BITS = lrfp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrfp_pkg::ctrl_cmd_t          cmd_i,
  output lrfp_pkg::dp_stat_t           stat_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_narrow_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  input  logic [lrfp_pkg::COLOR_W-1:0] line_color_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic [lrfp_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o
);
  import lrfp_pkg::*;

  localparam int LenW = COORD_BITS + 1;
  localparam int RemW = COORD_BITS + 2;
  localparam int AccW = COORD_BITS + FRAC_WIDE + 2;

  // config register
  logic narrow_q;

  // line state
  logic                         busy_q;
  logic                         frac_q;
  logic                         y_major_q;
  logic                         step_down_q;
  logic signed [COORD_BITS-1:0] major_pos_q;
  logic signed [COORD_BITS-1:0] major_end_q;
  logic [AccW-1:0]              accum_q;
  logic [INC_W-1:0]             inc_q;
  logic [COLOR_W-1:0]           color_q;

  // divider state
  logic [LenW-1:0]  div_l_q;
  logic [RemW-1:0]  rem_q;
  logic [QUO_W-1:0] quo_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;

  // output register
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [COLOR_W-1:0]           pcol_q;
  logic                         pval_q, plast_q;

  // setup
  logic signed [LenW-1:0] dx, dy, long_len, short_len;
  logic [LenW-1:0]        adx, ady, abs_long, abs_short;
  logic                   ymaj;
  logic signed [COORD_BITS-1:0] minor_start, major_start, major_stop;
  logic [AccW-1:0]        ms_ext, acc_init;

  assign dx  = {x_end_i[COORD_BITS-1], x_end_i} - {x_start_i[COORD_BITS-1], x_start_i};
  assign dy  = {y_end_i[COORD_BITS-1], y_end_i} - {y_start_i[COORD_BITS-1], y_start_i};
  assign adx = dx[LenW-1] ? -dx : dx;
  assign ady = dy[LenW-1] ? -dy : dy;
  assign ymaj = ady > adx;

  assign long_len    = ymaj ? dy : dx;
  assign short_len   = ymaj ? dx : dy;
  assign abs_long    = ymaj ? ady : adx;
  assign abs_short   = ymaj ? adx : ady;
  assign minor_start = ymaj ? x_start_i : y_start_i;
  assign major_start = ymaj ? y_start_i : x_start_i;
  assign major_stop  = ymaj ? y_end_i : x_end_i;

  assign ms_ext   = {{(AccW-COORD_BITS){minor_start[COORD_BITS-1]}}, minor_start};
  assign acc_init = narrow_q
                  ? (ms_ext << FRAC_NARROW) + AccW'(HALF_NARROW)
                  : (ms_ext << FRAC_WIDE) + AccW'(HALF_WIDE);

  // divider step: compare, restore, shift
  logic             ge;
  logic [RemW-1:0]  rem_sub;
  logic [QUO_W-1:0] quo_next;
  logic [INC_W-1:0] quo_ext;

  assign ge       = rem_q >= RemW'(div_l_q);
  assign rem_sub  = ge ? rem_q - RemW'(div_l_q) : rem_q;
  assign quo_next = {quo_q[QUO_W-2:0], ge};
  assign quo_ext  = INC_W'(quo_next);
  assign stat_o.div_last = cmd_i.div_step && (cnt_q == '0);

  // stepper
  logic signed [COORD_BITS-1:0] minor;
  logic                         last;
  logic [AccW-1:0]              inc_ext;

  assign minor   = frac_q ? accum_q[FRAC_NARROW +: COORD_BITS]
                          : accum_q[FRAC_WIDE +: COORD_BITS];
  assign last    = major_pos_q == major_end_q;
  assign inc_ext = {{(AccW-INC_W){inc_q[INC_W-1]}}, inc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_q <= 1'b0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) narrow_q <= cfg_narrow_i;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= narrow_q ? CNT_W'(FRAC_NARROW) : CNT_W'(FRAC_WIDE);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.advance && busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      frac_q      <= narrow_q;
      y_major_q   <= ymaj;
      step_down_q <= long_len[LenW-1] || (long_len == '0);
      major_pos_q <= major_start;
      major_end_q <= major_stop;
      accum_q     <= acc_init;
      color_q     <= line_color_i;
      div_l_q     <= abs_long;
      rem_q       <= RemW'(abs_short);
      quo_q       <= '0;
      neg_q       <= long_len[LenW-1] ^ short_len[LenW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_sub << 1;
      quo_q <= quo_next;
      if (cnt_q == '0) begin
        if (div_l_q == '0) inc_q <= '0;
        else inc_q <= neg_q ? -quo_ext : quo_ext;
      end
    end else if (cmd_i.advance && busy_q && !last) begin
      if (step_down_q) begin
        major_pos_q <= major_pos_q - 1'b1;
        accum_q     <= accum_q - inc_ext;
      end else begin
        major_pos_q <= major_pos_q + 1'b1;
        accum_q     <= accum_q + inc_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start || (cmd_i.advance && !busy_q)) begin
      px_q    <= '0;
      py_q    <= '0;
      pcol_q  <= '0;
      pval_q  <= 1'b0;
      plast_q <= 1'b0;
    end else if (cmd_i.advance) begin
      px_q    <= y_major_q ? minor : major_pos_q;
      py_q    <= y_major_q ? major_pos_q : minor;
      pcol_q  <= color_q;
      pval_q  <= 1'b1;
      plast_q <= last;
    end
  end

  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign pixel_valid_o = pval_q;
  assign last_pixel_o  = plast_q;

endmodule

// ===== rtl/core/line_rasterizer_fixed_point_top.sv =====
// Top level of the fixed-point DDA line rasterizer.
//
// item_i carries transactions: action start loads two endpoints and a color,
// action advance asks for the next pixel of the loaded line. Every item gives
// exactly one transaction on pixel_o. A start answers with pixel_valid 0 and
// all fields zero; an advance with no line loaded answers the same way.
// cfg_i writes narrow_fraction (0: 16 fraction bits, 1: 8); it is latched per
// line at start. cfg_i is always ready.
// A result appears on pixel_o in the cycle after its item is accepted.
// Advances are taken one per cycle while pixel_o is not stalled. A start
// blocks item_i after acceptance while the restoring divider forms the
// minor increment one quotient bit per cycle. A new start abandons any
// unfinished line.
// pixel_o has a single output register; item_i is ready while no divide runs
// and that register is empty or being drained, so a stalled receiver stalls the input.
// Reset clears the handshake, the divider sequencer, the line busy flag and
// the fraction register.
module line_rasterizer_fixed_point_top #(
  parameter int COORD_BITS = lrfp_pkg::COORD_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  lrfp_item_if.sink   item_i,
  lrfp_pixel_if.source pixel_o,
  lrfp_cfg_if.sink    cfg_i
);
  import lrfp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_i.ready = 1'b1;

  lrfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_action_i (item_i.action),
    .in_ready_o  (item_i.ready),
    .out_valid_o (pixel_o.valid),
    .out_ready_i (pixel_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lrfp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_i.valid),
    .cfg_narrow_i  (cfg_i.narrow_fraction),
    .x_start_i     (item_i.x_start),
    .y_start_i     (item_i.y_start),
    .x_end_i       (item_i.x_end),
    .y_end_i       (item_i.y_end),
    .line_color_i  (item_i.line_color),
    .pixel_x_o     (pixel_o.pixel_x),
    .pixel_y_o     (pixel_o.pixel_y),
    .pixel_color_o (pixel_o.pixel_color),
    .pixel_valid_o (pixel_o.pixel_valid),
    .last_pixel_o  (pixel_o.last_pixel)
  );

endmodule

// ===== rtl/core/lrfp_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
module lrfp_checker #(
  parameter int COORD_BITS = lrfp_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] pixel_x_i,
  input logic signed [COORD_BITS-1:0] pixel_y_i,
  input logic [lrfp_pkg::COLOR_W-1:0] pixel_color_i,
  input logic                         pixel_valid_i,
  input logic                         last_pixel_i
);

  // every accepted item yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
  else $error("no result after accepted item");

  // no new item is taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !(in_valid_i && in_ready_i))
  else $error("item accepted over a pending result");

  // a non-pixel result carries only zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !pixel_valid_i) |->
      (!last_pixel_i && pixel_x_i == '0 && pixel_y_i == '0 && pixel_color_i == '0))
  else $error("non-pixel result has nonzero fields");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i) &&
       $stable(pixel_color_i) && $stable(pixel_valid_i) && $stable(last_pixel_i)))
  else $error("stalled result changed");

endmodule

bind line_rasterizer_fixed_point_top lrfp_checker #(
  .COORD_BITS (COORD_BITS)
) u_lrfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (pixel_o.valid),
  .out_ready_i   (pixel_o.ready),
  .pixel_x_i     (pixel_o.pixel_x),
  .pixel_y_i     (pixel_o.pixel_y),
  .pixel_color_i (pixel_o.pixel_color),
  .pixel_valid_i (pixel_o.pixel_valid),
  .last_pixel_i  (pixel_o.last_pixel)
);
